>>> sv/sttk_pkg.sv
// Shared types, constants and character-class helpers for the source text tokenizer.
// No dependencies; imported by sttk_scan, sttk_out_fifo and source_text_tokenizer.
package sttk_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 16;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_QUOTE   = 8'h22;

    localparam logic [2:0] KW_LEN [3] = '{3'd2, 3'd4, 3'd6};

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_NUM     = 3'd1,
        MODE_IDENT   = 3'd2,
        MODE_STR     = 3'd3,
        MODE_COMMENT = 3'd4,
        MODE_DEAD    = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        KIND_NUMBER  = 3'd0,
        KIND_IDENT   = 3'd1,
        KIND_KEYWORD = 3'd2,
        KIND_STRING  = 3'd3,
        KIND_SYMBOL  = 3'd4,
        KIND_UNKNOWN = 3'd5,
        KIND_EOF     = 3'd6,
        KIND_BADSTR  = 3'd7
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] line;
        logic [15:0] col;
        logic [15:0] len;
        logic [1:0]  kw;
        logic [7:0]  sym;
        logic        last;
    } tok_t;

    // up to two tokens produced by one input transaction
    typedef struct packed {
        logic [1:0] n;
        tok_t       r0;
        tok_t       r1;
    } push_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return (c >= 8'h21) && (c <= 8'h7E) && !is_digit(c) && !is_alpha(c);
    endfunction

    // keyword text: 0 "if", 1 "else", 2 "return"
    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] pos);
        logic [7:0] r;
        r = 8'h00;
        case (k)
            2'd0: begin
                case (pos)
                    3'd0: r = 8'h69;
                    3'd1: r = 8'h66;
                    default: r = 8'h00;
                endcase
            end
            2'd1: begin
                case (pos)
                    3'd0: r = 8'h65;
                    3'd1: r = 8'h6C;
                    3'd2: r = 8'h73;
                    3'd3: r = 8'h65;
                    default: r = 8'h00;
                endcase
            end
            2'd2: begin
                case (pos)
                    3'd0: r = 8'h72;
                    3'd1: r = 8'h65;
                    3'd2: r = 8'h74;
                    3'd3: r = 8'h75;
                    3'd4: r = 8'h72;
                    3'd5: r = 8'h6E;
                    default: r = 8'h00;
                endcase
            end
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

>>> sv/sttk_scan.sv
// Scanner state machine: position counters, token tracking and token generation.
// Depends on sttk_pkg.
module sttk_scan #(
    parameter int COUNT_WIDTH = sttk_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_accept,
    input  logic [7:0]      in_ch,
    input  logic            in_end,
    output sttk_pkg::push_t push
);
    import sttk_pkg::*;

    localparam int CW = COUNT_WIDTH;

    mode_t          mode_reg,  mode_next;
    logic [CW-1:0]  line_reg,  line_next;
    logic [CW-1:0]  col_reg,   col_next;
    logic [CW-1:0]  start_reg, start_next;
    logic [CW-1:0]  run_reg,   run_next;
    logic [2:0]     mask_reg,  mask_next;

    function automatic logic [CW-1:0] inc_sat(input logic [CW-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [15:0] to16(input logic [CW-1:0] v);
        logic [CW+15:0] w;
        w = {16'h0000, v};
        if (w > (CW + 16)'(16'hFFFF)) begin
            return 16'hFFFF;
        end
        return w[15:0];
    endfunction

    function automatic logic [2:0] kw_filter(input logic [2:0] m, input logic [CW-1:0] pos,
                                             input logic [7:0] c);
        logic [2:0] r;
        r = m;
        for (int k = 0; k < 3; k++) begin
            if (pos >= CW'(KW_LEN[k]) || kw_char(2'(k), pos[2:0]) != c) begin
                r[k] = 1'b0;
            end
        end
        return r;
    endfunction

    logic c_digit, c_alpha, c_space, c_punct, c_word, c_nl, c_quote, c_dollar;

    assign c_digit  = is_digit(in_ch);
    assign c_alpha  = is_alpha(in_ch);
    assign c_space  = is_space(in_ch);
    assign c_punct  = is_punct(in_ch);
    assign c_nl     = (in_ch == CH_NEWLINE);
    assign c_quote  = (in_ch == CH_QUOTE);
    assign c_dollar = (in_ch == CH_DOLLAR);
    assign c_word   = c_alpha || c_digit || (in_ch == CH_UNDER);

    // pending-token termination (output block only) and idle-scan decision (shared by both blocks)
    logic term_pending;
    logic run_idle;

    always_comb begin
        term_pending = 1'b0;
        run_idle     = 1'b0;
        unique case (mode_reg)
            MODE_NUM:     begin term_pending = !c_digit; run_idle = !c_digit; end
            MODE_IDENT:   begin term_pending = !c_word;  run_idle = !c_word;  end
            MODE_STR:     term_pending = c_quote || c_nl;
            MODE_COMMENT: run_idle = c_nl;
            MODE_IDLE:    run_idle = 1'b1;
            default:      run_idle = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        logic adv;
        adv        = 1'b0;
        mode_next  = mode_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        start_next = start_reg;
        run_next   = run_reg;
        mask_next  = mask_reg;
        if (in_end) begin
            mode_next  = MODE_IDLE;
            line_next  = CW'(1);
            col_next   = '0;
            start_next = '0;
            run_next   = '0;
            mask_next  = 3'b111;
        end else begin
            unique case (mode_reg)
                MODE_NUM: begin
                    if (c_digit) begin
                        run_next = inc_sat(run_reg);
                        adv      = 1'b1;
                    end
                end
                MODE_IDENT: begin
                    if (c_word) begin
                        mask_next = kw_filter(mask_reg, run_reg, in_ch);
                        run_next  = inc_sat(run_reg);
                        adv       = 1'b1;
                    end
                end
                MODE_STR: begin
                    adv = 1'b1;
                    if (c_quote) begin
                        mode_next = MODE_IDLE;
                    end else if (c_nl) begin
                        mode_next = MODE_DEAD;
                    end else begin
                        run_next = inc_sat(run_reg);
                    end
                end
                MODE_COMMENT: begin
                    if (!c_nl) begin
                        adv = 1'b1;
                    end
                end
                MODE_IDLE: adv = 1'b0;
                default:   adv = 1'b1;
            endcase
            if (run_idle) begin
                adv       = 1'b1;
                mode_next = MODE_IDLE;
                if (c_space) begin
                    mode_next = MODE_IDLE;
                end else if (c_digit) begin
                    mode_next  = MODE_NUM;
                    start_next = col_reg;
                    run_next   = CW'(1);
                end else if (c_alpha || in_ch == CH_UNDER) begin
                    mode_next  = MODE_IDENT;
                    start_next = col_reg;
                    mask_next  = kw_filter(3'b111, '0, in_ch);
                    run_next   = CW'(1);
                end else if (c_quote) begin
                    mode_next  = MODE_STR;
                    start_next = col_reg;
                    run_next   = '0;
                end else if (c_dollar) begin
                    mode_next = MODE_COMMENT;
                end
            end
            if (adv) begin
                if (c_nl) begin
                    line_next = inc_sat(line_reg);
                    col_next  = '0;
                end else begin
                    col_next = inc_sat(col_reg);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            line_reg  <= CW'(1);
            col_reg   <= '0;
            start_reg <= '0;
            run_reg   <= '0;
            mask_reg  <= 3'b111;
        end else if (in_accept) begin
            mode_reg  <= mode_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            start_reg <= start_next;
            run_reg   <= run_next;
            mask_reg  <= mask_next;
        end
    end

    // outputs: token A is the pending token, token B the symbol/unknown or EOF
    always_comb begin
        tok_t a, b;
        logic va, vb;
        logic is_kw;
        logic [1:0] kw_idx;
        is_kw  = 1'b0;
        kw_idx = 2'd0;
        for (int k = 2; k >= 0; k--) begin
            if (mask_reg[k] && run_reg == CW'(KW_LEN[k])) begin
                is_kw  = 1'b1;
                kw_idx = 2'(k);
            end
        end

        a.kind = KIND_NUMBER;
        a.line = to16(line_reg);
        a.col  = to16(start_reg);
        a.len  = to16(run_reg);
        a.kw   = 2'd0;
        a.sym  = 8'h00;
        a.last = 1'b0;
        unique case (mode_reg)
            MODE_NUM:   a.kind = KIND_NUMBER;
            MODE_IDENT: begin
                a.kind = is_kw ? KIND_KEYWORD : KIND_IDENT;
                a.kw   = is_kw ? kw_idx : 2'd0;
            end
            MODE_STR:   a.kind = (in_end || !c_quote) ? KIND_BADSTR : KIND_STRING;
            default:    a.kind = KIND_NUMBER;
        endcase

        b.line = to16(line_reg);
        b.col  = to16(col_reg);
        b.last = 1'b1;
        if (in_end) begin
            va     = (mode_reg == MODE_NUM) || (mode_reg == MODE_IDENT) ||
                     (mode_reg == MODE_STR);
            vb     = 1'b1;
            b.kind = KIND_EOF;
            b.len  = 16'd0;
            b.kw   = 2'd0;
            b.sym  = 8'h00;
        end else begin
            va     = term_pending;
            vb     = run_idle && !c_space && !c_word && !c_quote && !c_dollar;
            b.kind = c_punct ? KIND_SYMBOL : KIND_UNKNOWN;
            b.len  = 16'd1;
            b.kw   = 2'd0;
            b.sym  = in_ch;
        end

        push.n  = in_accept ? (2'(va) + 2'(vb)) : 2'd0;
        push.r1 = b;
        if (va) begin
            push.r0      = a;
            push.r0.last = !vb;
        end else begin
            push.r0 = b;
        end
    end

`ifndef NO_ASSERTIONS
    a_push_needs_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        push.n != 2'd0 |-> in_accept)
        else $error("tokens produced without an accepted transaction");

    a_end_gives_eof: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && in_end |->
            (push.n == 2'd1 && push.r0.kind == KIND_EOF) ||
            (push.n == 2'd2 && push.r1.kind == KIND_EOF))
        else $error("end of input without trailing EOF token");

    a_end_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && in_end |=> mode_reg == MODE_IDLE && line_reg == CW'(1) && col_reg == '0)
        else $error("scanner state not restored after end of input");

    a_line_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        line_reg != '0)
        else $error("line counter reached zero");
`endif

endmodule

>>> sv/sttk_out_fifo.sv
// Four-entry token queue between the scanner and the result channel; takes up to
// two tokens per cycle, delivers one per cycle while out_ready is high. Depends on sttk_pkg.
module sttk_out_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  sttk_pkg::push_t push,
    output logic            space_ok,
    output logic            out_valid,
    input  logic            out_ready,
    output sttk_pkg::tok_t  out_tok
);
    import sttk_pkg::*;

    tok_t                  mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic                  pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_tok   = mem[rd_ptr_reg];
    assign space_ok  = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));

    always_comb begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push.n);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        count_next  = count_reg + FIFO_CNT_W'(push.n) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.n != 2'd0) begin
            mem[wr_ptr_reg] <= push.r0;
        end
        if (push.n == 2'd2) begin
            mem[wr_ptr_reg + FIFO_PTR_W'(1)] <= push.r1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("token queue count out of range");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push.n != 2'd0 |-> count_reg + FIFO_CNT_W'(push.n) <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("token queue overflow");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == FIFO_CNT_W'(FIFO_DEPTH)) || (wr_ptr_reg - rd_ptr_reg ==
            FIFO_PTR_W'(count_reg)))
        else $error("token queue pointers disagree with count");
`endif

endmodule

>>> sv/source_text_tokenizer.sv
// Source text tokenizer: one source byte per transaction in, token descriptors out.
// Depends on sttk_pkg, sttk_scan and sttk_out_fifo.
//
// Input channel (s_): s_tdata[7:0] is the source byte, s_tlast marks end of input
// (byte ignored, pending token and an end-of-file token are emitted).
// Result channel (m_): one token descriptor per transaction; m_tlast is high on
// the final token caused by an input byte.
// Tokens caused by a byte are written into the token queue and leave it in order on m_.
// Throughput: one byte per cycle while m_tready is high and each byte yields at most one
// token; a byte that yields two tokens takes two result transactions. The 4-entry
// token queue holds s_tready low while fewer than two entries are free.
// Reset: synchronous on aresetn low; queue emptied, line 1, column 0, idle scan.
// A stalled receiver holds the head token on m_ and backs up into s_tready once
// the queue fills; no token is lost or repeated.
module source_text_tokenizer #(
    parameter int COUNT_WIDTH = sttk_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,   // is_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [2:0] token_kind, [18:3] line_number,
                                   // [34:19] start_column, [50:35] token_length,
                                   // [52:51] keyword_index, [60:53] symbol_char
    output logic        m_tlast    // last
);
    import sttk_pkg::*;

    push_t push;
    tok_t  head;
    logic  in_accept;

    assign in_accept = s_tvalid && s_tready;

    sttk_scan #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_ch     (s_tdata),
        .in_end    (s_tlast),
        .push      (push)
    );

    sttk_out_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .space_ok  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_tok   (head)
    );

    assign m_tdata = {3'b000, head.sym, head.kw, head.len, head.col, head.line, head.kind};
    assign m_tlast = head.last;

endmodule
